### hdl/cosine_similarity_unit_assert.svh
// ----------------------------------------------------------------------------
// cosine similarity unit assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef COSINE_SIMILARITY_UNIT_ASSERT_SVH
`define COSINE_SIMILARITY_UNIT_ASSERT_SVH

// same-cycle implication, checked out of reset
`define CSU_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define CSU_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/csu_pkg.sv
// ----------------------------------------------------------------------------
// csu_pkg
// widths, limits and controller commands of the cosine similarity unit
// ----------------------------------------------------------------------------
package csu_pkg;

	// element and vector limits
	localparam int ELEM_W     = 16;
	localparam int MAX_LENGTH = 4096;
	localparam int CNT_W      = $clog2(MAX_LENGTH + 2);

	// accumulator widths
	localparam int DOT_W  = 2 * ELEM_W - 1 + $clog2(MAX_LENGTH) + 1;
	localparam int NORM_W = 2 * ELEM_W - 1 + $clog2(MAX_LENGTH);
	localparam int MAG_W  = NORM_W;

	// final computation widths
	localparam int PROD_W     = 2 * MAG_W;
	localparam int FRAC_SHIFT = 30;
	localparam int DIV_W      = PROD_W + FRAC_SHIFT;
	localparam int QUO_W      = FRAC_SHIFT + 1;
	localparam int ROOT_W     = 16;
	localparam int SIM_W      = 16;
	localparam int STEP_W     = $clog2(MAG_W);

	localparam logic [SIM_W-1:0] SIM_MAX = {1'b0, {(SIM_W - 1){1'b1}}};

	// controller to datapath commands
	typedef struct packed {
		logic acc_en;
		logic acc_last;
		logic mul_step;
		logic div_init;
		logic div_step;
		logic sqrt_step;
		logic out_load;
	} cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic out_free;
	} status_t;

endpackage

### hdl/csu_ctrl.sv
// ----------------------------------------------------------------------------
// csu_ctrl
// sequencer for accumulation, multiply, divide, root and result load
// ----------------------------------------------------------------------------
module csu_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_last,
	output logic              in_ready,
	input  csu_pkg::status_t  status,
	output csu_pkg::cmd_t     cmd
);

	typedef enum logic [2:0] {
		ST_ACCUM,
		ST_MUL,
		ST_DIV_INIT,
		ST_DIV,
		ST_SQRT,
		ST_FIN
	} state_t;

	state_t                     state_q;
	logic [csu_pkg::STEP_W-1:0] step_q;

	// command decode
	always_comb begin
		cmd           = '0;
		in_ready      = 1'b0;
		case (state_q)
			ST_ACCUM: begin
				in_ready     = 1'b1;
				cmd.acc_en   = in_valid;
				cmd.acc_last = in_valid && in_last;
			end
			ST_MUL:      cmd.mul_step  = 1'b1;
			ST_DIV_INIT: cmd.div_init  = 1'b1;
			ST_DIV:      cmd.div_step  = 1'b1;
			ST_SQRT:     cmd.sqrt_step = 1'b1;
			ST_FIN:      cmd.out_load  = status.out_free;
			default:     cmd           = '0;
		endcase
	end

	// state and step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_ACCUM;
			step_q  <= '0;
		end else begin
			case (state_q)
				ST_ACCUM: begin
					step_q <= '0;
					if (in_valid && in_last) state_q <= ST_MUL;
				end
				ST_MUL: begin
					if (step_q == csu_pkg::STEP_W'(csu_pkg::MAG_W - 1)) begin
						step_q  <= '0;
						state_q <= ST_DIV_INIT;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				ST_DIV_INIT: begin
					step_q  <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (step_q == csu_pkg::STEP_W'(csu_pkg::QUO_W - 1)) begin
						step_q  <= '0;
						state_q <= ST_SQRT;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				ST_SQRT: begin
					if (step_q == csu_pkg::STEP_W'(csu_pkg::ROOT_W - 1)) begin
						step_q  <= '0;
						state_q <= ST_FIN;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				ST_FIN: begin
					if (status.out_free) state_q <= ST_ACCUM;
				end
				default: state_q <= ST_ACCUM;
			endcase
		end
	end

endmodule

### hdl/csu_dp.sv
// ----------------------------------------------------------------------------
// csu_dp
// accumulators, shift-add multipliers, restoring divider, bitwise root
// and the output word register
// ----------------------------------------------------------------------------
module csu_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic signed [csu_pkg::ELEM_W-1:0] a_value,
	input  logic signed [csu_pkg::ELEM_W-1:0] b_value,
	input  csu_pkg::cmd_t                     cmd,
	output csu_pkg::status_t                  status,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic        [csu_pkg::SIM_W-1:0]  similarity,
	output logic                              undefined
);

	// running sums
	logic signed [csu_pkg::DOT_W-1:0]  dot_q;
	logic        [csu_pkg::NORM_W-1:0] norm_a_q;
	logic        [csu_pkg::NORM_W-1:0] norm_b_q;
	logic        [csu_pkg::CNT_W-1:0]  count_q;

	logic signed [2*csu_pkg::ELEM_W-1:0] ab;
	logic signed [2*csu_pkg::ELEM_W-1:0] aa;
	logic signed [2*csu_pkg::ELEM_W-1:0] bb;
	logic                                in_range;
	logic signed [csu_pkg::DOT_W-1:0]    dot_nx;
	logic        [csu_pkg::NORM_W-1:0]   norm_a_nx;
	logic        [csu_pkg::NORM_W-1:0]   norm_b_nx;
	logic        [csu_pkg::CNT_W-1:0]    count_nx;
	logic        [csu_pkg::MAG_W-1:0]    dot_abs;
	logic                                neg_nx;
	logic                                undef_nx;

	// final computation registers
	logic                                neg_q;
	logic                                undef_q;
	logic [csu_pkg::PROD_W-1:0]          mc_d_q;
	logic [csu_pkg::MAG_W-1:0]           mp_d_q;
	logic [csu_pkg::PROD_W-1:0]          pr_d_q;
	logic [csu_pkg::PROD_W-1:0]          mc_p_q;
	logic [csu_pkg::MAG_W-1:0]           mp_p_q;
	logic [csu_pkg::PROD_W-1:0]          pr_p_q;
	logic [csu_pkg::DIV_W-1:0]           rem_q;
	logic [csu_pkg::DIV_W-1:0]           dvs_q;
	logic [csu_pkg::QUO_W-1:0]           quo_q;
	logic [csu_pkg::ROOT_W-1:0]          root_q;
	logic [csu_pkg::ROOT_W-1:0]          mask_q;

	logic [csu_pkg::ROOT_W-1:0]          cand;
	logic [2*csu_pkg::ROOT_W-1:0]        cand_sq;
	logic                                rem_ge;
	logic [csu_pkg::SIM_W-1:0]           sim_nx;

	// element products and next sums
	always_comb begin
		ab        = a_value * b_value;
		aa        = a_value * a_value;
		bb        = b_value * b_value;
		in_range  = count_q < csu_pkg::CNT_W'(csu_pkg::MAX_LENGTH);
		dot_nx    = dot_q;
		norm_a_nx = norm_a_q;
		norm_b_nx = norm_b_q;
		count_nx  = csu_pkg::CNT_W'(csu_pkg::MAX_LENGTH + 1);
		if (in_range) begin
			dot_nx    = dot_q + csu_pkg::DOT_W'(ab);
			norm_a_nx = norm_a_q + csu_pkg::NORM_W'(unsigned'(aa));
			norm_b_nx = norm_b_q + csu_pkg::NORM_W'(unsigned'(bb));
			count_nx  = count_q + 1'b1;
		end
		neg_nx   = dot_nx[csu_pkg::DOT_W-1];
		dot_abs  = neg_nx ? csu_pkg::MAG_W'(unsigned'(-dot_nx))
			: csu_pkg::MAG_W'(unsigned'(dot_nx));
		undef_nx = (count_nx > csu_pkg::CNT_W'(csu_pkg::MAX_LENGTH))
			|| (norm_a_nx == '0) || (norm_b_nx == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dot_q    <= '0;
			norm_a_q <= '0;
			norm_b_q <= '0;
			count_q  <= '0;
		end else if (cmd.acc_en) begin
			if (cmd.acc_last) begin
				dot_q    <= '0;
				norm_a_q <= '0;
				norm_b_q <= '0;
				count_q  <= '0;
			end else begin
				dot_q    <= dot_nx;
				norm_a_q <= norm_a_nx;
				norm_b_q <= norm_b_nx;
				count_q  <= count_nx;
			end
		end
	end

	// shift-add multipliers: dot magnitude squared and norm product
	always_ff @(posedge clk) begin
		if (cmd.acc_last) begin
			neg_q   <= neg_nx;
			undef_q <= undef_nx;
			mc_d_q  <= csu_pkg::PROD_W'(dot_abs);
			mp_d_q  <= dot_abs;
			pr_d_q  <= '0;
			mc_p_q  <= csu_pkg::PROD_W'(norm_a_nx);
			mp_p_q  <= norm_b_nx;
			pr_p_q  <= '0;
		end else if (cmd.mul_step) begin
			if (mp_d_q[0]) pr_d_q <= pr_d_q + mc_d_q;
			if (mp_p_q[0]) pr_p_q <= pr_p_q + mc_p_q;
			mc_d_q <= mc_d_q << 1;
			mc_p_q <= mc_p_q << 1;
			mp_d_q <= mp_d_q >> 1;
			mp_p_q <= mp_p_q >> 1;
		end
	end

	// restoring divider, one quotient bit per cycle
	assign rem_ge = rem_q >= dvs_q;

	always_ff @(posedge clk) begin
		if (cmd.div_init) begin
			rem_q <= {pr_d_q, csu_pkg::FRAC_SHIFT'(0)};
			dvs_q <= {pr_p_q, csu_pkg::FRAC_SHIFT'(0)};
			quo_q <= '0;
		end else if (cmd.div_step) begin
			if (rem_ge) rem_q <= rem_q - dvs_q;
			dvs_q <= dvs_q >> 1;
			quo_q <= {quo_q[csu_pkg::QUO_W-2:0], rem_ge};
		end
	end

	// integer square root, one result bit per cycle
	assign cand    = root_q | mask_q;
	assign cand_sq = cand * cand;

	always_ff @(posedge clk) begin
		if (cmd.div_init) begin
			root_q <= '0;
			mask_q <= {1'b1, (csu_pkg::ROOT_W - 1)'(0)};
		end else if (cmd.sqrt_step) begin
			if (cand_sq <= (2*csu_pkg::ROOT_W)'(quo_q)) root_q <= cand;
			mask_q <= mask_q >> 1;
		end
	end

	// sign and saturation of the result
	always_comb begin
		if (undef_q) begin
			sim_nx = '0;
		end else if (neg_q) begin
			sim_nx = csu_pkg::SIM_W'(-root_q);
		end else begin
			sim_nx = root_q[csu_pkg::ROOT_W-1] ? csu_pkg::SIM_MAX : root_q;
		end
	end

	// output word register
	assign status.out_free = !out_valid || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			similarity <= sim_nx;
			undefined  <= undef_q;
		end
	end

endmodule

### hdl/cosine_similarity_unit.sv
// ----------------------------------------------------------------------------
// cosine_similarity_unit
// cosine similarity of two streamed vectors as signed Q1.15
// ----------------------------------------------------------------------------
// usage:
//   the slave side takes one element pair per word, a in the low half of
//   tdata and b in the high half; tlast marks the final pair of a vector.
//   pairs that are not last are taken one per cycle.
//   after the last pair the unit works on the result and holds tready low:
//   shift-add multiply, a divider setup step, restoring division and
//   bitwise square root; the result word then loads into the output
//   register once that register is free, and the next vector may start
//   after the load.
//   the master side gives similarity in tdata and the undefined flag in
//   tuser (zero norm or more than 4096 pairs; similarity is then zero).
//   a result that waits for tready stays in the output register while the
//   next vector streams in; a further result waits until it is taken.
//   reset clears all sums, empties the output register and raises tready.
// ----------------------------------------------------------------------------
module cosine_similarity_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // a_value[15:0], b_value[31:16]
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,  // similarity[15:0]
	output logic        m_axis_tuser   // undefined[0]
);

	csu_pkg::cmd_t    cmd;
	csu_pkg::status_t status;

	// sequencer
	csu_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_last  (s_axis_tlast),
		.in_ready (s_axis_tready),
		.status   (status),
		.cmd      (cmd)
	);

	// arithmetic and output register
	csu_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.a_value    (s_axis_tdata[15:0]),
		.b_value    (s_axis_tdata[31:16]),
		.cmd        (cmd),
		.status     (status),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.similarity (m_axis_tdata),
		.undefined  (m_axis_tuser)
	);

endmodule

### hdl/csu_checker.sv
// ----------------------------------------------------------------------------
// csu_checker
// port-level checks of the cosine similarity unit, bound to the top level
// ----------------------------------------------------------------------------
`include "cosine_similarity_unit_assert.svh"

module csu_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        s_axis_tlast,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [15:0] m_axis_tdata,
	input logic        m_axis_tuser
);

	// stalled result word stays offered
	`CSU_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid,
		"result word dropped while stalled")

	// stalled result word keeps its payload
	`CSU_ASSERT_NEXT(a_out_stable, m_axis_tvalid && !m_axis_tready,
		$stable(m_axis_tdata) && $stable(m_axis_tuser), "result payload changed while stalled")

	// undefined result carries zero similarity
	`CSU_ASSERT_NOW(a_undef_zero, m_axis_tvalid && m_axis_tuser, m_axis_tdata == 16'h0000,
		"undefined result with nonzero similarity")

	// input closes while a vector result is computed
	`CSU_ASSERT_NEXT(a_busy_after_last, s_axis_tvalid && s_axis_tready && s_axis_tlast,
		!s_axis_tready, "input open right after last pair")

endmodule

bind cosine_similarity_unit csu_checker u_csu_checker (.*);

### sim/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for cosine_similarity_unit: streams element pairs with
// random gaps and output stalls, keeps its own running sums and exact integer
// root/divide, and compares every similarity word against that prediction
// ----------------------------------------------------------------------------
module tb;

	// one result word as the master side carries it
	typedef struct packed {
		logic [csu_pkg::SIM_W-1:0] similarity;
		logic                      undef_flag;
	} sim_word_t;

	// content styles for random vectors
	typedef enum int {
		FILL_RANDOM,
		FILL_SMALL,
		FILL_PARALLEL,
		FILL_ZERO_SIDE,
		FILL_CORNERS,
		FILL_NOISY
	} fill_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata;
	logic        s_axis_tlast;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [15:0] m_axis_tdata;
	logic        m_axis_tuser;

	// predictor state
	longint    dot_acc;
	longint    norm_a_acc;
	longint    norm_b_acc;
	int        pair_count;
	sim_word_t similarity_q[$];

	// run bookkeeping
	int mismatch_count;
	int pairs_sent;
	int vectors_sent;
	int words_checked;
	int in_gap_max;
	int out_gap_max;

	cosine_similarity_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// hard limit on run length
	initial begin
		#20_000_000;
		$display("tb: done, errors");
		$finish;
	end

	// largest q in 0..32768 with q*q*na*nb <= dot*dot*2^30
	function automatic int unsigned cosine_mag(bit [63:0] dot_mag, bit [63:0] na,
		bit [63:0] nb);
		bit [127:0]  rhs;
		bit [127:0]  norm_prod;
		bit [127:0]  lhs;
		int unsigned lo;
		int unsigned hi;
		int unsigned mid;
		rhs = dot_mag;
		rhs = (rhs * rhs) << csu_pkg::FRAC_SHIFT;
		norm_prod = na;
		norm_prod = norm_prod * nb;
		lo = 0;
		hi = 32768;
		while (lo < hi) begin
			mid = lo + (hi - lo + 1) / 2;
			lhs = mid;
			lhs = lhs * mid * norm_prod;
			if (lhs <= rhs) begin
				lo = mid;
			end else begin
				hi = mid - 1;
			end
		end
		return lo;
	endfunction

	// fold one accepted pair into the sums, queue the similarity on last
	task automatic accumulate_pair(input logic signed [15:0] a_val,
		input logic signed [15:0] b_val, input logic last_flag);
		sim_word_t   w;
		bit          neg;
		bit [63:0]   mag;
		int unsigned q;
		if (pair_count < csu_pkg::MAX_LENGTH) begin
			dot_acc    += longint'(a_val) * longint'(b_val);
			norm_a_acc += longint'(a_val) * longint'(a_val);
			norm_b_acc += longint'(b_val) * longint'(b_val);
			pair_count++;
		end else begin
			pair_count = csu_pkg::MAX_LENGTH + 1;
		end
		if (last_flag) begin
			if (pair_count > csu_pkg::MAX_LENGTH || norm_a_acc == 0 || norm_b_acc == 0) begin
				w.similarity = '0;
				w.undef_flag = 1'b1;
			end else begin
				neg = dot_acc < 0;
				mag = neg ? -dot_acc : dot_acc;
				q = cosine_mag(mag, norm_a_acc, norm_b_acc);
				if (neg) begin
					w.similarity = 16'(32'h10000 - q);
				end else begin
					w.similarity = (q > 32767) ? csu_pkg::SIM_MAX : 16'(q);
				end
				w.undef_flag = 1'b0;
			end
			similarity_q.insert(similarity_q.size(), w);
			dot_acc    = 0;
			norm_a_acc = 0;
			norm_b_acc = 0;
			pair_count = 0;
			vectors_sent++;
		end
	endtask

	// offer one pair after a random gap and wait until it is taken
	task automatic send_pair(input logic signed [15:0] a_val,
		input logic signed [15:0] b_val, input logic last_flag);
		int gap;
		gap = $urandom_range(0, in_gap_max);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {b_val, a_val};
		s_axis_tlast  <= last_flag;
		do @(posedge clk); while (s_axis_tready !== 1'b1);
		accumulate_pair(a_val, b_val, last_flag);
		pairs_sent++;
	endtask

	// pick one corner element
	function automatic logic signed [15:0] corner_value();
		case ($urandom_range(0, 4))
			0: return -16'sd32768;
			1: return -16'sd1;
			2: return 16'sd0;
			3: return 16'sd1;
			default: return 16'sd32767;
		endcase
	endfunction

	// one well-formed vector with content of the given style
	task automatic send_vector(input int len, input fill_t fill);
		logic signed [15:0] a_val;
		logic signed [15:0] b_val;
		bit                 zero_a;
		zero_a = $urandom_range(0, 1);
		for (int i = 0; i < len; i++) begin
			a_val = 16'($urandom);
			b_val = 16'($urandom);
			case (fill)
				FILL_SMALL: begin
					a_val = 16'($signed($urandom_range(0, 15)) - 8);
					b_val = 16'($signed($urandom_range(0, 15)) - 8);
				end
				FILL_PARALLEL: begin
					b_val = $urandom_range(0, 1) ? a_val : -a_val;
				end
				FILL_ZERO_SIDE: begin
					if (zero_a) a_val = '0;
					else b_val = '0;
				end
				FILL_CORNERS: begin
					a_val = corner_value();
					b_val = corner_value();
				end
				FILL_NOISY: begin
					b_val = a_val + 16'($signed($urandom_range(0, 63)) - 32);
				end
				default: begin
				end
			endcase
			send_pair(a_val, b_val, i == len - 1);
		end
	endtask

	// result side: random stalls, then check each word taken
	initial begin : result_check
		int        stall;
		sim_word_t want;
		m_axis_tready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = $urandom_range(0, out_gap_max);
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (m_axis_tvalid !== 1'b1);
			words_checked++;
			if (similarity_q.size() == 0) begin
				$error("similarity word 0x%04h/%0b with none pending", m_axis_tdata,
					m_axis_tuser);
				mismatch_count++;
			end else begin
				want = similarity_q.pop_front();
				if (m_axis_tdata !== want.similarity) begin
					$error("similarity: expected %0d, got %0d",
						$signed(want.similarity), $signed(m_axis_tdata));
					mismatch_count++;
				end
				if (m_axis_tuser !== want.undef_flag) begin
					$error("undefined: expected %0b, got %0b", want.undef_flag, m_axis_tuser);
					mismatch_count++;
				end
			end
		end
	end

	// extremes, zero norms, orthogonal and parallel vectors
	task automatic test_directed();
		send_pair(16'sd32767, 16'sd32767, 1'b1);
		send_pair(-16'sd32768, -16'sd32768, 1'b1);
		send_pair(16'sd32767, -16'sd32767, 1'b1);
		send_pair(-16'sd32768, 16'sd32767, 1'b1);
		send_pair(16'sd0, 16'sd5, 1'b1);
		send_pair(16'sd7, 16'sd0, 1'b1);
		send_pair(16'sd0, 16'sd0, 1'b1);
		send_pair(16'sd1, 16'sd0, 1'b0);
		send_pair(16'sd0, 16'sd1, 1'b1);
		send_pair(16'sd0, 16'sd3, 1'b0);
		send_pair(16'sd5, 16'sd0, 1'b1);
		send_pair(16'sh5555, 16'shAAAA, 1'b0);
		send_pair(16'shAAAA, 16'sh5555, 1'b0);
		send_pair(-16'sd1, 16'sd1, 1'b1);
		send_pair(16'sd3, 16'sd4, 1'b0);
		send_pair(16'sd4, 16'sd3, 1'b1);
		send_pair(16'sd1, 16'sd1, 1'b0);
		send_pair(16'sd1, -16'sd1, 1'b1);
		send_pair(-16'sd1, -16'sd1, 1'b1);
	endtask

	// random vectors of mixed length and content, idle on or off per vector
	task automatic test_random_vectors(input int pair_budget);
		int    start_pairs;
		int    len;
		int    pick;
		fill_t fill;
		start_pairs = pairs_sent;
		while (pairs_sent - start_pairs < pair_budget) begin
			pick = $urandom_range(0, 99);
			if (pick < 70) len = $urandom_range(1, 8);
			else if (pick < 95) len = $urandom_range(9, 64);
			else len = $urandom_range(65, 300);
			fill = fill_t'($urandom_range(0, 5));
			if ($urandom_range(0, 4) == 0) begin
				in_gap_max  = 0;
				out_gap_max = 0;
			end else begin
				in_gap_max  = 8;
				out_gap_max = 8;
			end
			send_vector(len, fill);
		end
		in_gap_max  = 8;
		out_gap_max = 8;
	endtask

	// stimulus
	initial begin
		arst_n         = 1'b0;
		s_axis_tvalid  = 1'b0;
		s_axis_tdata   = '0;
		s_axis_tlast   = 1'b0;
		dot_acc        = 0;
		norm_a_acc     = 0;
		norm_b_acc     = 0;
		pair_count     = 0;
		mismatch_count = 0;
		pairs_sent     = 0;
		vectors_sent   = 0;
		words_checked  = 0;
		in_gap_max     = 8;
		out_gap_max    = 8;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random_vectors(1600);

		s_axis_tvalid <= 1'b0;
		s_axis_tlast  <= 1'b0;
		while (similarity_q.size() != 0) @(posedge clk);
		repeat (120) @(posedge clk);

		$display("tb: %0d vectors, %0d element pairs streamed", vectors_sent, pairs_sent);
		$display("tb: %0d similarity words checked, %0d mismatches", words_checked,
			mismatch_count);
		if (mismatch_count == 0) begin
			$display("tb: done, clean");
		end else begin
			$display("tb: done, errors");
		end
		$finish;
	end

endmodule
